>>> hw/rtl/dja_pkg.sv
// Shared constants, types and helpers for the deadline job admission unit.
package dja_pkg;

    localparam int SLOTS    = 1024;
    localparam int LEVELS   = $clog2(SLOTS);
    localparam int NODE_W   = LEVELS + 1;
    localparam int NODES    = 2 * SLOTS;
    localparam int SPAN_W   = LEVELS + 1;
    localparam int VAL_W    = LEVELS + 3;
    localparam int HZ_W     = 11;
    localparam int DL_W     = 16;
    localparam int PROFIT_W = 32;
    localparam int TOTAL_W  = 48;
    localparam int CMP_W    = (SPAN_W > DL_W) ? SPAN_W : DL_W;

    localparam logic [HZ_W-1:0] HZ_RESET  = 11'd1024;
    localparam logic            CMD_START = 1'b0;
    localparam logic            CMD_JOB   = 1'b1;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [NODE_W-1:0]       node_t;
    typedef logic [SPAN_W-1:0]       span_t;

    // a: pending add over the whole subtree, t: subtree minimum below it
    typedef struct packed {
        val_t a;
        val_t t;
    } node_word_t;

    typedef enum logic [1:0] {
        ALU_LEAF,
        ALU_SIB,
        ALU_PAR
    } alu_op_t;

    typedef struct packed {
        alu_op_t    op;
        logic       inc;
        logic       left;
        node_word_t mem;
        val_t       cur;
        val_t       sib;
    } alu_req_t;

    typedef struct packed {
        logic       we;
        node_t      addr;
        node_word_t data;
    } ram_wr_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LEAF_RD,
        ST_LEAF_UPD,
        ST_SIB_UPD,
        ST_PAR_UPD,
        ST_CHECK,
        ST_EMIT
    } dja_state_t;

    function automatic span_t clamp_span(input logic [HZ_W-1:0] h);
        logic [CMP_W-1:0] hx;
        logic [CMP_W-1:0] res;
        begin
            hx = CMP_W'(h);
            if (hx == '0)
                res = CMP_W'(1);
            else if (hx > CMP_W'(SLOTS))
                res = CMP_W'(SLOTS);
            else
                res = hx;
            return span_t'(res);
        end
    endfunction

endpackage

>>> hw/rtl/dja_if.sv
// Request and response channel interfaces of the deadline job admission unit.
interface dja_req_if import dja_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [DL_W-1:0]     deadline;
    logic [PROFIT_W-1:0] profit;

    modport source (output valid, cmd, deadline, profit, input ready);
    modport sink (input valid, cmd, deadline, profit, output ready);
endinterface

interface dja_rsp_if import dja_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               accepted;
    logic [TOTAL_W-1:0] total_profit;

    modport source (output valid, accepted, total_profit, input ready);
    modport sink (input valid, accepted, total_profit, output ready);
endinterface

>>> hw/rtl/dja_ram.sv
// Generic single write port, single read port RAM with registered read data.
module dja_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/dja_alu.sv
// Shared node unit: leaf step, sibling lazy add and parent minimum recompute.
module dja_alu import dja_pkg::*; (
    input  alu_req_t   req,
    output node_word_t res
);

    val_t delta;
    val_t mem_a;
    val_t mem_t;
    val_t cur;
    val_t sib;
    val_t lower;

    always_comb
    begin
        delta = req.inc ? val_t'(1) : {VAL_W{1'b1}};
        mem_a = req.mem.a;
        mem_t = req.mem.t;
        cur   = req.cur;
        sib   = req.sib;
        lower = (cur < sib) ? cur : sib;
        res   = req.mem;
        case (req.op)
            ALU_LEAF:
            begin
                res.t = mem_t + delta;
            end
            ALU_SIB:
            begin
                if (req.left)
                begin
                    res.a = mem_a + delta;
                    res.t = mem_t + delta;
                end
            end
            ALU_PAR:
            begin
                res.t = lower + mem_a;
            end
            default:
            begin
                res = req.mem;
            end
        endcase
    end

endmodule

>>> hw/rtl/dja_seq.sv
// Sequencer: tree sweep, suffix decrement walk, undo walk, profit total, result word.
module dja_seq import dja_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    dja_req_if.sink         req,
    dja_rsp_if.source       rsp,
    input  logic [HZ_W-1:0] hz,
    output alu_req_t        alu_req,
    input  node_word_t      alu_res,
    output ram_wr_t         ram_wr,
    output node_t           ram_raddr,
    input  node_word_t      ram_rdata
);

    dja_state_t           state_reg, state_next;
    node_t                node_reg, node_next;
    node_t                leaf_reg, leaf_next;
    val_t                 cur_reg, cur_next;
    val_t                 sib_reg, sib_next;
    val_t                 lo_reg, lo_next;
    span_t                step_reg, step_next;
    span_t                span_reg, span_next;
    logic                 undo_reg, undo_next;
    logic                 ok_reg, ok_next;
    logic                 sweep_rsp_reg, sweep_rsp_next;
    logic [PROFIT_W-1:0]  profit_reg, profit_next;
    logic [TOTAL_W-1:0]   sum_reg, sum_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic                 rsp_acc_reg, rsp_acc_next;
    logic [TOTAL_W-1:0]   rsp_total_reg, rsp_total_next;

    logic                 ready;
    node_t                parent;
    node_t                sibling;
    logic [CMP_W-1:0]     dl_x;
    logic [CMP_W-1:0]     span_x;
    logic [CMP_W-1:0]     dl_pos;
    node_t                leaf_idx;
    logic [TOTAL_W:0]     sum_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            node_reg      <= node_t'(1);
            lo_reg        <= val_t'(1);
            step_reg      <= span_t'(SLOTS);
            span_reg      <= clamp_span(HZ_RESET);
            undo_reg      <= 1'b0;
            ok_reg        <= 1'b0;
            sweep_rsp_reg <= 1'b0;
            sum_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            node_reg      <= node_next;
            lo_reg        <= lo_next;
            step_reg      <= step_next;
            span_reg      <= span_next;
            undo_reg      <= undo_next;
            ok_reg        <= ok_next;
            sweep_rsp_reg <= sweep_rsp_next;
            sum_reg       <= sum_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        leaf_reg      <= leaf_next;
        cur_reg       <= cur_next;
        sib_reg       <= sib_next;
        profit_reg    <= profit_next;
        rsp_acc_reg   <= rsp_acc_next;
        rsp_total_reg <= rsp_total_next;
    end

    assign parent   = node_t'(node_reg >> 1);
    assign sibling  = node_reg ^ node_t'(1);
    assign dl_x     = CMP_W'(req.deadline);
    assign span_x   = CMP_W'(span_reg);
    assign dl_pos   = ((dl_x > span_x) ? span_x : dl_x) - CMP_W'(1);
    assign leaf_idx = {1'b1, dl_pos[LEVELS-1:0]};
    assign sum_wide = {1'b0, sum_reg} + (TOTAL_W + 1)'(profit_reg);

    always_comb
    begin
        state_next     = state_reg;
        node_next      = node_reg;
        leaf_next      = leaf_reg;
        cur_next       = cur_reg;
        sib_next       = sib_reg;
        lo_next        = lo_reg;
        step_next      = step_reg;
        span_next      = span_reg;
        undo_next      = undo_reg;
        ok_next        = ok_reg;
        sweep_rsp_next = sweep_rsp_reg;
        profit_next    = profit_reg;
        sum_next       = sum_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_acc_next   = rsp_acc_reg;
        rsp_total_next = rsp_total_reg;
        ready          = 1'b0;
        ram_wr         = '0;
        ram_raddr      = '0;
        alu_req.op     = ALU_LEAF;
        alu_req.inc    = undo_reg;
        alu_req.left   = ~node_reg[0];
        alu_req.mem    = ram_rdata;
        alu_req.cur    = cur_reg;
        alu_req.sib    = sib_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_wr.we     = 1'b1;
                ram_wr.addr   = node_reg;
                ram_wr.data.a = '0;
                ram_wr.data.t = lo_reg;
                ok_next       = 1'b0;
                if (node_reg == '1)
                begin
                    // the sweep after reset answers nothing
                    state_next = sweep_rsp_reg ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    node_next = node_reg + node_t'(1);
                    // last node of a level: next level starts at slot 1
                    if ((node_reg & (node_reg + node_t'(1))) == '0)
                    begin
                        step_next = span_t'(step_reg >> 1);
                        lo_next   = val_t'(1);
                    end
                    else
                    begin
                        lo_next = lo_reg + val_t'(step_reg);
                    end
                end
            end
            ST_IDLE:
            begin
                ready = 1'b1;
                if (req.valid)
                begin
                    ok_next = 1'b0;
                    if (req.cmd == CMD_START)
                    begin
                        node_next      = node_t'(1);
                        lo_next        = val_t'(1);
                        step_next      = span_t'(SLOTS);
                        span_next      = clamp_span(hz);
                        sum_next       = '0;
                        sweep_rsp_next = 1'b1;
                        state_next     = ST_CLEAR;
                    end
                    else if (req.deadline == '0)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        node_next   = leaf_idx;
                        leaf_next   = leaf_idx;
                        undo_next   = 1'b0;
                        profit_next = req.profit;
                        state_next  = ST_LEAF_RD;
                    end
                end
            end
            ST_LEAF_RD:
            begin
                ram_raddr  = node_reg;
                state_next = ST_LEAF_UPD;
            end
            ST_LEAF_UPD:
            begin
                alu_req.op   = ALU_LEAF;
                ram_wr.we    = 1'b1;
                ram_wr.addr  = node_reg;
                ram_wr.data  = alu_res;
                cur_next     = alu_res.t;
                ram_raddr    = sibling;
                state_next   = ST_SIB_UPD;
            end
            ST_SIB_UPD:
            begin
                alu_req.op   = ALU_SIB;
                ram_wr.we    = 1'b1;
                ram_wr.addr  = sibling;
                ram_wr.data  = alu_res;
                sib_next     = alu_res.t;
                ram_raddr    = parent;
                state_next   = ST_PAR_UPD;
            end
            ST_PAR_UPD:
            begin
                alu_req.op   = ALU_PAR;
                ram_wr.we    = 1'b1;
                ram_wr.addr  = parent;
                ram_wr.data  = alu_res;
                cur_next     = alu_res.t;
                node_next    = parent;
                if (parent == node_t'(1))
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    ram_raddr  = parent ^ node_t'(1);
                    state_next = ST_SIB_UPD;
                end
            end
            ST_CHECK:
            begin
                if (undo_reg)
                begin
                    ok_next    = 1'b0;
                    state_next = ST_EMIT;
                end
                else if (cur_reg[VAL_W-1])
                begin
                    // global minimum negative: walk again adding one back
                    undo_next  = 1'b1;
                    node_next  = leaf_reg;
                    state_next = ST_LEAF_RD;
                end
                else
                begin
                    ok_next    = 1'b1;
                    sum_next   = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_acc_next   = ok_reg;
                    rsp_total_next = sum_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req.ready        = ready;
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.accepted     = rsp_acc_reg;
    assign rsp.total_profit = rsp_total_reg;

endmodule

>>> hw/rtl/deadline_job_admission_unit.sv
// Deadline job admission unit: top level with horizon register, sequencer, node unit and tree memory.
// A job word (cmd = 1) walks the tree path from its deadline leaf to the root once when the job is
// admitted; when it is refused it walks the path a second time to take the decrement back. A job
// with a deadline of zero is answered without a walk. A start word (cmd = 0), and reset, rebuild
// the slack tree by writing the node memory one node a cycle, all 2*SLOTS-1 nodes, during which no
// word is taken. Every walk step is one read-modify-write of the single node memory through the
// shared node unit. A horizon write is latched at the next start word; a result word waits
// in the output register and the next job is taken meanwhile.
module deadline_job_admission_unit import dja_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    dja_req_if.sink         req,
    dja_rsp_if.source       rsp,
    input  logic            cfg_we,
    input  logic [HZ_W-1:0] cfg_wdata
);

    logic [HZ_W-1:0] hz_reg;
    alu_req_t        alu_req;
    node_word_t      alu_res;
    ram_wr_t         ram_wr;
    node_t           ram_raddr;
    node_word_t      ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hz_reg <= HZ_RESET;
        end
        else if (cfg_we)
        begin
            hz_reg <= cfg_wdata;
        end
    end

    dja_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .hz        (hz_reg),
        .alu_req   (alu_req),
        .alu_res   (alu_res),
        .ram_wr    (ram_wr),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    dja_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    dja_ram #(
        .WIDTH ($bits(node_word_t)),
        .DEPTH (NODES)
    ) u_tree_ram (
        .clk   (clk),
        .we    (ram_wr.we),
        .waddr (ram_wr.addr),
        .wdata (ram_wr.data),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

>>> hw/rtl/dja_checker.sv
// Port-level checker for the deadline job admission unit, bound to the top level.
module dja_checker import dja_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               req_cmd,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic               rsp_accepted,
    input logic [TOTAL_W-1:0] rsp_total_profit
);

    // a stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accepted)
            && $stable(rsp_total_profit))
        else $error("result word changed while stalled");

    // one word at a time
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous word in progress");

    // a fresh result only appears once the unit is free again
    a_rsp_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> req_ready)
        else $error("result raised while unit still busy");

    // start word triggers the rebuild sweep
    a_start_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_cmd == CMD_START) |=> !req_ready ##1 !req_ready)
        else $error("start word did not rebuild the tree");

endmodule

bind deadline_job_admission_unit dja_checker u_dja_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .req_cmd          (req.cmd),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_accepted     (rsp.accepted),
    .rsp_total_profit (rsp.total_profit)
);

>>> bench/deadline_job_admission_unit_tb.sv
// Self-checking testbench for deadline_job_admission_unit: directed table, then random batches.
module deadline_job_admission_unit_tb;
    import dja_pkg::*;

    localparam int RANDOM_JOBS = 1500;
    localparam int HOLD_CYCLES = 3000;
    localparam int TAIL_CYCLES = 64;

    typedef struct packed {
        logic               accepted;
        logic [TOTAL_W-1:0] total_profit;
    } verdict_t;

    typedef struct packed {
        logic                wr_hz;
        logic [HZ_W-1:0]     hz;
        logic                cmd;
        logic [DL_W-1:0]     dl;
        logic [PROFIT_W-1:0] pr;
        logic                typed;
        logic                acc;
        logic [TOTAL_W-1:0]  total;
    } drow_t;

    localparam drow_t DIRECTED [0:24] = '{
        '{1'b0, 11'd0,    CMD_JOB,   16'd0,      32'd5,          1'b1, 1'b0, 48'd0},
        '{1'b0, 11'd0,    CMD_JOB,   16'd1,      32'hFFFF_FFFF,  1'b1, 1'b1, 48'hFFFF_FFFF},
        '{1'b0, 11'd0,    CMD_JOB,   16'd1,      32'd7,          1'b1, 1'b0, 48'hFFFF_FFFF},
        '{1'b0, 11'd0,    CMD_JOB,   16'hFFFF,   32'd1,          1'b1, 1'b1, 48'h1_0000_0000},
        '{1'b0, 11'd0,    CMD_JOB,   16'd1024,   32'd0,          1'b1, 1'b1, 48'h1_0000_0000},
        '{1'b0, 11'd0,    CMD_START, 16'd0,      32'd0,          1'b1, 1'b0, 48'd0},
        '{1'b1, 11'd0,    CMD_START, 16'd0,      32'd0,          1'b1, 1'b0, 48'd0},
        '{1'b0, 11'd0,    CMD_JOB,   16'hFFFF,   32'd3,          1'b1, 1'b1, 48'd3},
        '{1'b0, 11'd0,    CMD_JOB,   16'd1,      32'd9,          1'b1, 1'b0, 48'd3},
        '{1'b0, 11'd0,    CMD_JOB,   16'd0,      32'd9,          1'b1, 1'b0, 48'd3},
        '{1'b1, 11'd2047, CMD_JOB,   16'd2,      32'd4,          1'b1, 1'b0, 48'd3},
        '{1'b0, 11'd0,    CMD_START, 16'hFFFF,   32'hFFFF_FFFF,  1'b1, 1'b0, 48'd0},
        '{1'b0, 11'd0,    CMD_JOB,   16'd1024,   32'hFFFF_FFFF,  1'b1, 1'b1, 48'hFFFF_FFFF},
        '{1'b1, 11'd1,    CMD_START, 16'd0,      32'd0,          1'b1, 1'b0, 48'd0},
        '{1'b0, 11'd0,    CMD_JOB,   16'd1,      32'd1,          1'b1, 1'b1, 48'd1},
        '{1'b1, 11'd3,    CMD_START, 16'd0,      32'd0,          1'b1, 1'b0, 48'd0},
        '{1'b0, 11'd0,    CMD_JOB,   16'd3,      32'd10,         1'b0, 1'b0, 48'd0},
        '{1'b0, 11'd0,    CMD_JOB,   16'd3,      32'd20,         1'b0, 1'b0, 48'd0},
        '{1'b0, 11'd0,    CMD_JOB,   16'd3,      32'd30,         1'b0, 1'b0, 48'd0},
        '{1'b0, 11'd0,    CMD_JOB,   16'd3,      32'd40,         1'b1, 1'b0, 48'd60},
        '{1'b0, 11'd0,    CMD_JOB,   16'd2,      32'd50,         1'b1, 1'b0, 48'd60},
        '{1'b1, 11'd1024, CMD_START, 16'd0,      32'd0,          1'b1, 1'b0, 48'd0},
        '{1'b0, 11'd0,    CMD_JOB,   16'h8000,   32'h8000_0000,  1'b1, 1'b1, 48'h8000_0000},
        '{1'b1, 11'd1025, CMD_START, 16'd0,      32'd0,          1'b1, 1'b0, 48'd0},
        '{1'b0, 11'd0,    CMD_JOB,   16'd1024,   32'd1,          1'b1, 1'b1, 48'd1}
    };

    logic            clk = 1'b0;
    logic            rst_n;
    logic            cfg_we;
    logic [HZ_W-1:0] cfg_wdata;

    dja_req_if req_ch ();
    dja_rsp_if rsp_ch ();

    deadline_job_admission_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // schedule state: horizon register, latched span, per-slot slack, profit total
    logic [HZ_W-1:0]    horizon_reg;
    int                 batch_span;
    int                 slot_slack [1:SLOTS];
    logic [TOTAL_W-1:0] profit_total;

    verdict_t pending_verdicts [$];
    int       mismatches;
    int       results_seen;
    int       admitted_seen;
    int       jobs_offered;
    int       starts_offered;
    int       horizons_written;
    bit       steady;
    bit       hold_off_req;

    function automatic void judge_admission(input logic cmd, input logic [DL_W-1:0] dl,
                                            input logic [PROFIT_W-1:0] pr,
                                            output verdict_t v);
        int               d;
        int               t;
        bit               fits;
        logic [TOTAL_W:0] sum;
        v.accepted = 1'b0;
        if (cmd == CMD_START)
        begin
            if (horizon_reg == '0)
                batch_span = 1;
            else if (int'(horizon_reg) > SLOTS)
                batch_span = SLOTS;
            else
                batch_span = int'(horizon_reg);
            for (t = 1; t <= SLOTS; t++)
                slot_slack[t] = t;
            profit_total = '0;
        end
        else if (dl != '0)
        begin
            d = (int'(dl) > batch_span) ? batch_span : int'(dl);
            fits = 1'b1;
            for (t = d; t <= batch_span; t++)
                if (slot_slack[t] < 1)
                    fits = 1'b0;
            if (fits)
            begin
                for (t = d; t <= batch_span; t++)
                    slot_slack[t]--;
                v.accepted = 1'b1;
                sum = {1'b0, profit_total} + pr;
                profit_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            end
        end
        v.total_profit = profit_total;
    endfunction

    function automatic logic [HZ_W-1:0] pick_horizon();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return HZ_W'($urandom_range(1, 24));
        else if (r < 70)
            return '0;
        else if (r < 80)
            return HZ_W'($urandom_range(25, SLOTS));
        else if (r < 90)
            return HZ_W'($urandom_range(SLOTS, 2047));
        return HZ_W'($urandom_range(0, 2047));
    endfunction

    task automatic offer_word(input logic cmd, input logic [DL_W-1:0] dl,
                              input logic [PROFIT_W-1:0] pr, input logic typed,
                              input verdict_t typed_v);
        verdict_t v;
        if (!steady)
            while ($urandom_range(0, 99) < 16)
            begin
                req_ch.valid <= 1'b0;
                @(negedge clk);
            end
        req_ch.valid    <= 1'b1;
        req_ch.cmd      <= cmd;
        req_ch.deadline <= dl;
        req_ch.profit   <= pr;
        @(posedge clk);
        while (!(req_ch.valid && req_ch.ready))
            @(posedge clk);
        judge_admission(cmd, dl, pr, v);
        pending_verdicts.push_back(typed ? typed_v : v);
        if (cmd == CMD_START)
            starts_offered++;
        else
            jobs_offered++;
        @(negedge clk);
    endtask

    // sender pauses until every outstanding word has come back
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_verdicts.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_horizon(input logic [HZ_W-1:0] hz);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= hz;
        @(negedge clk);
        cfg_we      <= 1'b0;
        horizon_reg = hz;
        horizons_written++;
    endtask

    function automatic void note_mismatch(input string what, input verdict_t want,
                                          input verdict_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected accepted=%0d total=%0h, got accepted=%0d total=%0h",
                     $time, what, want.accepted, want.total_profit,
                     got.accepted, got.total_profit);
    endfunction

    always @(posedge clk)
    begin
        verdict_t got;
        verdict_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.accepted     = rsp_ch.accepted;
            got.total_profit = rsp_ch.total_profit;
            results_seen++;
            admitted_seen += int'(got.accepted === 1'b1);
            if (pending_verdicts.size() == 0)
                note_mismatch("unexpected result word", '0, got);
            else
            begin
                want = pending_verdicts.pop_front();
                if (got.accepted !== want.accepted)
                    note_mismatch("accepted differs", want, got);
                else if (got.total_profit !== want.total_profit)
                    note_mismatch("total_profit differs", want, got);
            end
        end
    end

    // result side: random back-pressure outside steady batches, a long hold-off on each request
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 16);
        end
    end

    initial
    begin
        #30_000_000;
        $display("FAIL deadline_job_admission_unit");
        $finish;
    end

    initial
    begin
        verdict_t            v;
        drow_t               row;
        int                  i;
        int                  k;
        int                  n;
        int                  r;
        int                  batch;
        int                  random_jobs;
        logic [DL_W-1:0]     dl;
        logic [PROFIT_W-1:0] pr;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        req_ch.valid    = 1'b0;
        req_ch.cmd      = CMD_START;
        req_ch.deadline = '0;
        req_ch.profit   = '0;
        steady          = 1'b0;
        hold_off_req    = 1'b0;
        mismatches      = 0;
        horizon_reg     = HZ_RESET;
        judge_admission(CMD_START, '0, '0, v);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < 25; i++)
        begin
            row = DIRECTED[i];
            if (row.wr_hz)
                write_horizon(row.hz);
            offer_word(row.cmd, row.dl, row.pr, row.typed, '{row.acc, row.total});
        end

        batch       = 0;
        random_jobs = 0;
        while (random_jobs < RANDOM_JOBS)
        begin
            batch++;
            steady = (batch >= 8 && batch < 12);
            write_horizon(pick_horizon());
            offer_word(CMD_START, DL_W'($urandom), $urandom, 1'b0, '0);
            n = $urandom_range(10, 60);
            if (batch == 5 || batch == 20)
                hold_off_req = 1'b1;
            for (k = 0; k < n; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    offer_word(CMD_START, DL_W'($urandom), $urandom, 1'b0, '0);
                else if (r < 4)
                    write_horizon(pick_horizon());
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 5)
                        dl = '0;
                    else if (r < 15)
                        dl = DL_W'($urandom_range(0, 65535));
                    else
                        dl = DL_W'($urandom_range(1, batch_span + 2));
                    r = $urandom_range(0, 99);
                    if (r < 10)
                        pr = '0;
                    else if (r < 20)
                        pr = '1;
                    else
                        pr = $urandom;
                    offer_word(CMD_JOB, dl, pr, 1'b0, '0);
                    random_jobs++;
                end
            end
            if (batch % 4 == 0)
                settle();
        end

        steady = 1'b0;
        settle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (pending_verdicts.size() != 0)
        begin
            mismatches++;
            $display("%0d result words never arrived", pending_verdicts.size());
        end

        $display("Run offered %0d jobs and %0d starts across %0d horizon writes.",
                 jobs_offered, starts_offered, horizons_written);
        $display("%0d result words checked, %0d jobs admitted, %0d refused.",
                 results_seen, admitted_seen, jobs_offered - admitted_seen);
        if (mismatches == 0)
            $display("PASS deadline_job_admission_unit");
        else
            $display("FAIL deadline_job_admission_unit");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/dja_pkg.sv
hw/rtl/dja_if.sv
hw/rtl/dja_ram.sv
hw/rtl/dja_alu.sv
hw/rtl/dja_seq.sv
hw/rtl/deadline_job_admission_unit.sv
hw/rtl/dja_checker.sv
bench/deadline_job_admission_unit_tb.sv
